// ===== hdl/esc_pkg.sv =====
// ============================================================================
// esc_pkg
// Shared types, constants and tables for the epoch seconds to calendar block.
// ============================================================================
package esc_pkg;

    typedef logic [31:0] t_secs;
    typedef logic [15:0] t_days;
    typedef logic [16:0] t_sod;
    typedef logic [11:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_dom;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_minute;
    typedef logic [5:0]  t_second;
    typedef logic [2:0]  t_weekday;

    typedef struct packed {
        t_hour   hour;
        t_minute minute;
        t_second second;
    } t_hms;

    typedef struct packed {
        t_year    year;
        t_month   month;
        t_dom     dom;
        t_weekday weekday;
        logic     beyond_2099;
    } t_cal;

    // Seconds are pre-shifted by seven bits, leaving a division by 675.
    localparam logic [25:0] DAY_RECIP   = 26'd50903316;
    localparam logic [9:0]  DAY_DIV     = 10'd675;
    // Exact reciprocals for the narrow divisions (rounded up).
    localparam logic [12:0] HOUR_RECIP  = 13'd4661;
    localparam logic [11:0] HOUR_SECS   = 12'd3600;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;
    localparam logic [5:0]  MIN_SECS    = 6'd60;
    localparam logic [15:0] CYCLE_RECIP = 16'd45934;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [9:0]  SEVEN_RECIP = 10'd586;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;

    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    // Day number of 1 March 2100; from there on a virtual 29 February is added.
    localparam logic [15:0] MAR_2100    = 16'd47541;
    localparam logic [11:0] CYCLE_BASE  = 12'd1969;

    // First day of each month within the year, counted from 0.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        base = 9'd0;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Month offsets of the weekday formula.
    function automatic logic [2:0] wk_offset(input logic [3:0] idx);
        logic [2:0] offs;
        case (idx)
            4'd0:    offs = 3'd0;
            4'd1:    offs = 3'd3;
            4'd2:    offs = 3'd3;
            4'd3:    offs = 3'd6;
            4'd4:    offs = 3'd1;
            4'd5:    offs = 3'd4;
            4'd6:    offs = 3'd6;
            4'd7:    offs = 3'd2;
            4'd8:    offs = 3'd5;
            4'd9:    offs = 3'd0;
            4'd10:   offs = 3'd3;
            4'd11:   offs = 3'd5;
            default: offs = 3'd0;
        endcase
        return offs;
    endfunction

endpackage

// ===== hdl/esc_split.sv =====
// ============================================================================
// esc_split
// Two-stage split of a seconds count into whole days and second of the day.
// ============================================================================
module esc_split (
    input  logic           i_clk,
    input  esc_pkg::t_secs i_secs,
    output esc_pkg::t_days o_days,
    output esc_pkg::t_sod  o_sod
);
    import esc_pkg::*;

    logic [24:0] w_x;
    logic [50:0] w_prod;
    logic [15:0] r_qe;
    t_secs       r_secs;

    logic [24:0] w_x2;
    logic [25:0] w_qm;
    logic [25:0] w_diff;
    logic [25:0] w_rem;
    logic        w_fix;
    t_days       n_days;
    t_sod        n_sod;
    t_days       r_days;
    t_sod        r_sod;

    // The low seven bits of the count pass straight into the second of the day.
    assign w_x    = i_secs[31:7];
    assign w_prod = 51'(w_x) * 51'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        r_qe   <= w_prod[50:35];
        r_secs <= i_secs;
    end

    // The quotient estimate is low by at most one.
    assign w_x2   = r_secs[31:7];
    assign w_qm   = 26'(r_qe) * 26'(DAY_DIV);
    assign w_diff = 26'(w_x2) - w_qm;
    assign w_fix  = (w_diff >= 26'(DAY_DIV));
    assign w_rem  = w_fix ? (w_diff - 26'(DAY_DIV)) : w_diff;
    assign n_days = r_qe + 16'(w_fix);
    assign n_sod  = {w_rem[9:0], r_secs[6:0]};

    always_ff @(posedge i_clk) begin
        r_days <= n_days;
        r_sod  <= n_sod;
    end

    assign o_days = r_days;
    assign o_sod  = r_sod;

endmodule

// ===== hdl/esc_time.sv =====
// ============================================================================
// esc_time
// Two-stage conversion of the second of the day into hour, minute, second.
// ============================================================================
module esc_time (
    input  logic          i_clk,
    input  esc_pkg::t_sod i_sod,
    output esc_pkg::t_hms o_hms
);
    import esc_pkg::*;

    logic [12:0] w_y;
    logic [24:0] w_hp;
    t_hour       w_hr;
    logic [16:0] w_rh;
    t_hour       r_hour;
    logic [11:0] r_rh;

    logic [23:0] w_mp;
    t_minute     w_mn;
    logic [11:0] w_sec;
    t_hms        r_hms;

    // 3600 is 16 times 225, so the division works on the upper bits.
    assign w_y  = i_sod[16:4];
    assign w_hp = 25'(w_y) * 25'(HOUR_RECIP);
    assign w_hr = w_hp[24:20];
    assign w_rh = i_sod - (17'(w_hr) * 17'(HOUR_SECS));

    always_ff @(posedge i_clk) begin
        r_hour <= w_hr;
        r_rh   <= w_rh[11:0];
    end

    assign w_mp  = 24'(r_rh) * 24'(MIN_RECIP);
    assign w_mn  = w_mp[23:18];
    assign w_sec = r_rh - (12'(w_mn) * 12'(MIN_SECS));

    always_ff @(posedge i_clk) begin
        r_hms.hour   <= r_hour;
        r_hms.minute <= w_mn;
        r_hms.second <= w_sec[5:0];
    end

    assign o_hms = r_hms;

endmodule

// ===== hdl/esc_date.sv =====
// ============================================================================
// esc_date
// Four-stage conversion of a day count into year, month, day and weekday.
// ============================================================================
module esc_date (
    input  logic           i_clk,
    input  esc_pkg::t_days i_days,
    output esc_pkg::t_cal  o_cal
);
    import esc_pkg::*;

    // Stage one: days since 1969-01-01 and the four-year cycle number.
    // Inside the range only 2100 breaks the four-year rule, so a virtual
    // 29 February is inserted there and every cycle ends in a leap year.
    logic        w_late;
    logic [15:0] w_dp;
    logic [31:0] w_cp;
    logic [15:0] r_dp;
    logic [5:0]  r_q4;

    assign w_late = (i_days >= MAR_2100);
    assign w_dp   = i_days + 16'(YEAR_DAYS) + 16'(w_late);
    assign w_cp   = 32'(w_dp) * 32'(CYCLE_RECIP);

    always_ff @(posedge i_clk) begin
        r_dp <= w_dp;
        r_q4 <= w_cp[31:26];
    end

    // Stage two: year within the cycle and day of the year.
    logic [15:0] w_r4;
    logic [1:0]  w_k;
    logic [10:0] w_doy;
    t_year       r_year2;
    logic [8:0]  r_doy;
    logic        r_leap;

    assign w_r4 = r_dp - (16'(r_q4) * 16'(CYCLE_DAYS));

    always_comb begin
        if (w_r4 >= 16'(3 * YEAR_DAYS)) begin
            w_k = 2'd3;
        end else if (w_r4 >= 16'(2 * YEAR_DAYS)) begin
            w_k = 2'd2;
        end else if (w_r4 >= 16'(YEAR_DAYS)) begin
            w_k = 2'd1;
        end else begin
            w_k = 2'd0;
        end
    end

    assign w_doy = w_r4[10:0] - (11'(w_k) * 11'(YEAR_DAYS));

    always_ff @(posedge i_clk) begin
        r_year2 <= CYCLE_BASE + {4'd0, r_q4, 2'b00} + 12'(w_k);
        r_doy   <= w_doy[8:0];
        r_leap  <= (w_k == 2'd3);
    end

    // Stage three: month and day of month, and the two-digit year term.
    logic [3:0]  w_mi;
    logic [8:0]  w_dom;
    logic [11:0] w_yl;
    t_year       r_year3;
    logic [3:0]  r_mi;
    t_dom        r_dom;
    logic [7:0]  r_yl;

    always_comb begin
        w_mi = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_doy >= month_start(r_leap, 4'(i))) begin
                w_mi = 4'(i);
            end
        end
    end

    assign w_dom = r_doy - month_start(r_leap, w_mi) + 9'd1;
    // Year modulo 100, plus 100 for the years 2000 to 2099 and from 2100 on.
    assign w_yl  = (r_year2 >= 12'd2100) ? (r_year2 - 12'd2000) : (r_year2 - 12'd1900);

    always_ff @(posedge i_clk) begin
        r_year3 <= r_year2;
        r_mi    <= w_mi;
        r_dom   <= w_dom[4:0];
        r_yl    <= w_yl[7:0];
    end

    // Stage four: weekday by the table formula, reduced modulo seven.
    logic        w_adj;
    logic [8:0]  w_acc;
    logic [18:0] w_wp;
    logic [8:0]  w_wd;
    t_cal        r_cal;

    assign w_adj = (r_yl[1:0] == 2'd0) && (r_mi < 4'd2);
    assign w_acc = 9'(r_yl) + 9'(r_yl[7:2]) + 9'(r_dom) + 9'(wk_offset(r_mi)) - 9'(w_adj);
    assign w_wp  = 19'(w_acc) * 19'(SEVEN_RECIP);
    assign w_wd  = w_acc - (9'(w_wp[18:12]) * 9'(WEEK_DAYS));

    always_ff @(posedge i_clk) begin
        r_cal.year        <= r_year3;
        r_cal.month       <= r_mi + 4'd1;
        r_cal.dom         <= r_dom;
        r_cal.weekday     <= w_wd[2:0];
        r_cal.beyond_2099 <= (r_year3 > 12'd2099);
    end

    assign o_cal = r_cal;

endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// ============================================================================
// epoch_seconds_to_calendar
// Converts a seconds-since-1970 count into calendar date, time and weekday.
// ============================================================================
// Usage:
//   A transaction is taken on every rising edge where start is high and busy
//   is low. busy is held low, so a new count may be offered in every cycle.
//   The count is registered, split into days and second of the day in two
//   stages, then the date path runs four stages while the time of day is
//   worked out in two and delayed to match.
//   The result is driven on the o_ ports with o_valid high for one cycle,
//   once the count has passed the input register, the two split stages
//   and the four date stages.
//   Throughput is one conversion per cycle, set by the fully pipelined
//   constant-reciprocal dividers; the date path is the longest chain.
//   The receiver cannot stall: each result is presented for exactly one
//   cycle and must be captured then.
//   A synchronous reset clears the valid pipeline, so no result appears
//   from counts offered before or during reset.
//   o_beyond_2099 flags years after 2099, where the weekday is unreliable.
// ============================================================================
module epoch_seconds_to_calendar (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  esc_pkg::t_secs    i_seconds_count,
    output logic              o_valid,
    output esc_pkg::t_year    o_year,
    output esc_pkg::t_month   o_month,
    output esc_pkg::t_dom     o_day_of_month,
    output esc_pkg::t_hour    o_hour,
    output esc_pkg::t_minute  o_minute,
    output esc_pkg::t_second  o_second,
    output esc_pkg::t_weekday o_weekday,
    output logic              o_beyond_2099
);
    import esc_pkg::*;

    logic        w_accept;
    logic [6:0]  r_vld;
    t_secs       r_secs;
    t_days       w_days;
    t_sod        w_sod;
    t_hms        w_hms;
    t_hms        r_hms_d1;
    t_hms        r_hms_d2;
    t_cal        w_cal;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_secs <= i_seconds_count;
        end
    end

    esc_split u_split (
        .i_clk  (i_clk),
        .i_secs (r_secs),
        .o_days (w_days),
        .o_sod  (w_sod)
    );

    esc_time u_time (
        .i_clk (i_clk),
        .i_sod (w_sod),
        .o_hms (w_hms)
    );

    esc_date u_date (
        .i_clk  (i_clk),
        .i_days (w_days),
        .o_cal  (w_cal)
    );

    // The time path is two stages shorter than the date path.
    always_ff @(posedge i_clk) begin
        r_hms_d1 <= w_hms;
        r_hms_d2 <= r_hms_d1;
    end

    assign o_valid        = r_vld[6];
    assign o_year         = w_cal.year;
    assign o_month        = w_cal.month;
    assign o_day_of_month = w_cal.dom;
    assign o_weekday      = w_cal.weekday;
    assign o_beyond_2099  = w_cal.beyond_2099;
    assign o_hour         = r_hms_d2.hour;
    assign o_minute       = r_hms_d2.minute;
    assign o_second       = r_hms_d2.second;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("result without a transaction seven cycles earlier");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1)
                    && (o_year >= 12'd1970) && (o_year <= 12'd2106))
        else $error("date field out of range");

    a_february: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month == 4'd2)) |-> (o_day_of_month <= 5'd29))
        else $error("February day beyond 29");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)
                    && (o_weekday < 3'd7))
        else $error("time or weekday field out of range");
`endif

endmodule

// ===== sim/epoch_seconds_to_calendar_tb.sv =====
// ============================================================================
// epoch_seconds_to_calendar_tb
// Self-checking testbench for the seconds-since-1970 to calendar converter.
// A directed set of boundary counts is followed by random counts, with the
// sender idling at varying rates. Every accepted count is converted by an
// independent predictor, and each strobed result is compared field by field
// with the oldest outstanding prediction.
// ============================================================================
module epoch_seconds_to_calendar_tb;

    import esc_pkg::*;

    localparam int unsigned SECS_IN_DAY    = 86400;
    localparam int unsigned SECS_IN_HOUR   = 3600;
    localparam int unsigned SECS_IN_MINUTE = 60;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_SAFE_YEAR = 2099;
    localparam int unsigned LAST_DAY_INDEX = 49709;
    localparam logic [31:0] START_OF_2100  = 32'd4102444800;
    localparam int unsigned MONTH_DAYS [0:11] = '{31, 28, 31, 30, 31, 30,
                                                  31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEK_OFFSET [0:11] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 12;
    localparam int          RANDOM_PER_PHASE = 450;

    typedef struct packed {
        t_year    year;
        t_month   month;
        t_dom     dom;
        t_hour    hour;
        t_minute  minute;
        t_second  second;
        t_weekday weekday;
        logic     beyond_2099;
    } calendar_t;

    function automatic bit is_leap_year(input int unsigned yr);
        if ((yr % 4) != 0) return 1'b0;
        if ((yr % 100) != 0) return 1'b1;
        return (yr % 400) == 0;
    endfunction

    function automatic calendar_t convert_seconds(input logic [31:0] secs);
        int unsigned days;
        int unsigned sod;
        int unsigned yr;
        int unsigned mon;
        int unsigned year_len;
        int unsigned month_len;
        int unsigned yl;
        int unsigned acc;
        calendar_t   res;
        days = secs / SECS_IN_DAY;
        sod  = secs % SECS_IN_DAY;
        yr   = FIRST_YEAR;
        mon  = 0;
        forever begin
            year_len = is_leap_year(yr) ? 366 : 365;
            if (days < year_len) break;
            days -= year_len;
            yr++;
        end
        while (mon < 11) begin
            month_len = MONTH_DAYS[mon];
            if (mon == 1 && is_leap_year(yr)) month_len = 29;
            if (days < month_len) break;
            days -= month_len;
            mon++;
        end
        // The weekday follows the two-digit-year table rule, which drifts
        // after 2099; that is the documented behaviour, so it is copied here.
        yl = yr % 100;
        if (yr / 100 > 19) yl += 100;
        acc = (yl + yl / 4) % 7 + (days + 1) + WEEK_OFFSET[mon];
        if ((yl % 4) == 0 && mon < 2) acc -= 1;
        res.year        = yr[11:0];
        res.month       = 4'(mon + 1);
        res.dom         = 5'(days + 1);
        res.hour        = 5'(sod / SECS_IN_HOUR);
        res.minute      = 6'((sod % SECS_IN_HOUR) / SECS_IN_MINUTE);
        res.second      = 6'((sod % SECS_IN_HOUR) % SECS_IN_MINUTE);
        res.weekday     = 3'(acc % 7);
        res.beyond_2099 = (yr > LAST_SAFE_YEAR);
        return res;
    endfunction

    function automatic string format_date(input calendar_t c);
        return $sformatf("%0d-%02d-%02d %02d:%02d:%02d wd=%0d late=%0b", c.year, c.month,
                         c.dom, c.hour, c.minute, c.second, c.weekday, c.beyond_2099);
    endfunction

    class calendar_scoreboard;
        calendar_t expected_dates [$];
        int        date_errors;

        function new();
            date_errors = 0;
        endfunction

        function void note_count(input logic [31:0] secs);
            expected_dates.push_back(convert_seconds(secs));
        endfunction

        function void check_date(input calendar_t got);
            calendar_t want;
            string     bad_fields;
            if (expected_dates.size() == 0) begin
                date_errors++;
                if (date_errors <= 10)
                    $display("ERROR: unexpected result %s", format_date(got));
                return;
            end
            want = expected_dates.pop_front();
            bad_fields = "";
            if (got.year !== want.year)               bad_fields = {bad_fields, " year"};
            if (got.month !== want.month)             bad_fields = {bad_fields, " month"};
            if (got.dom !== want.dom)                 bad_fields = {bad_fields, " day"};
            if (got.hour !== want.hour)               bad_fields = {bad_fields, " hour"};
            if (got.minute !== want.minute)           bad_fields = {bad_fields, " minute"};
            if (got.second !== want.second)           bad_fields = {bad_fields, " second"};
            if (got.weekday !== want.weekday)         bad_fields = {bad_fields, " weekday"};
            if (got.beyond_2099 !== want.beyond_2099) bad_fields = {bad_fields, " late_flag"};
            if (bad_fields != "") begin
                date_errors++;
                if (date_errors <= 10)
                    $display("ERROR: mismatch in%s: expected %s, got %s", bad_fields,
                             format_date(want), format_date(got));
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_secs       i_seconds_count = '0;
    logic        o_valid;
    t_year       o_year;
    t_month      o_month;
    t_dom        o_day_of_month;
    t_hour       o_hour;
    t_minute     o_minute;
    t_second     o_second;
    t_weekday    o_weekday;
    logic        o_beyond_2099;

    calendar_scoreboard board = new();
    int unsigned        sender_idle_pct = 0;
    int                 quiet_cycles = 0;

    epoch_seconds_to_calendar u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_seconds_count (i_seconds_count),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday),
        .o_beyond_2099   (o_beyond_2099)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Values read here are those from before the edge, so a transaction is
    // seen exactly as the block sees it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            board.note_count(i_seconds_count);
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            board.check_date({o_year, o_month, o_day_of_month, o_hour, o_minute,
                              o_second, o_weekday, o_beyond_2099});
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_count(input logic [31:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_seconds_count <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    function automatic logic [31:0] random_count();
        int unsigned pick;
        logic [31:0] day_base;
        pick = $urandom_range(99);
        day_base = $urandom_range(LAST_DAY_INDEX) * SECS_IN_DAY;
        if (pick < 50)
            return $urandom();
        else if (pick < 65)
            return day_base;
        else if (pick < 80)
            return day_base + SECS_IN_DAY - 1;
        else
            return $urandom_range(32'hFFFF_FFFF, START_OF_2100);
    endfunction

    initial begin
        logic [31:0] directed_counts [$];
        directed_counts = '{
            32'd0,              // the epoch itself
            32'hFFFF_FFFF,      // last representable second
            32'd86399, 32'd86400,
            32'd94608000,       // last day of a leap year
            32'd94694399,
            32'd946684799,      // turn of the millennium
            32'd946684800,
            32'd951782400,      // leap day in a century year divisible by 400
            32'd951868800,
            32'd2147483647, 32'd2147483648,
            32'd4102444799,     // last second before the weekday rule breaks
            32'd4102444800,
            32'd4107456000,     // 2100 has no leap day
            32'd4107542400,
            32'd4233686400,     // leap day beyond 2099
            32'hAAAA_AAAA, 32'h5555_5555
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 25;
        foreach (directed_counts[k]) send_count(directed_counts[k]);
        for (int n = 0; n < RANDOM_PER_PHASE; n++) send_count(random_count());
        wait_for_drain();

        sender_idle_pct = 67;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) send_count(random_count());
        wait_for_drain();

        sender_idle_pct = 0;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) send_count(random_count());
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.date_errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
